### src/slli_pkg.sv
package slli_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      logic                   ins;
      logic                   del;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   valid;
      logic                   take;   // cell is at or after the insert point
      logic                   seen;   // a match at this cell or to its left
   } cell_type;

endpackage

### src/slli_cell.sv
module slli_cell
   import slli_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  cell_type left,
   input  cell_type right,
   output cell_type self
);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   greater;
   logic                   match;

   assign greater = valid_ff && ($signed(cmd.value) < $signed(value_ff));
   assign match   = valid_ff && (value_ff == cmd.value);

   assign self.value = value_ff;
   assign self.valid = valid_ff;
   assign self.take  = greater || !valid_ff;
   assign self.seen  = left.seen || match;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.ins && self.take) begin
         value_in = left.take ? left.value : cmd.value;
         valid_in = valid_ff || left.valid;
      end else if (cmd.del && self.seen) begin
         value_in = right.value;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### src/sorted_list_insert_remove.sv
// channel | direction | words                        | handshake
// req_    | in        | op, value                    | req_valid / req_ready
// rsp_    | out       | status, count, smallest      | rsp_valid / rsp_ready
//
// One word per cycle while req_ready is high: a word's compare and
// shift across the cell chain finishes in the cycle it is accepted;
// its result word is registered; rsp_valid rises the cycle after.
// req_ready is high while the result register is empty or being taken.
// Reset empties the list at once; entry values are not cleared.
module sorted_list_insert_remove
   import slli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [COUNT_WIDTH-1:0]        rsp_count,
   output logic signed [VALUE_WIDTH-1:0] rsp_smallest
);

   localparam int CW = $clog2(CAPACITY + 1);

   cell_type cells [CAPACITY];
   cell_type lefts [CAPACITY];
   cell_type rights[CAPACITY];
   cmd_type  cmd;

   logic                   accept;
   logic                   full;
   logic                   found;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW+COUNT_WIDTH-1:0] count_ext;
   status_type             status_in;
   logic [VALUE_WIDTH-1:0] smallest_in;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic [VALUE_WIDTH-1:0] rsp_smallest_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = cells[CAPACITY-1].valid;
   assign found     = cells[CAPACITY-1].seen;

   assign cmd.ins   = accept && (req_op == OP_INSERT) && !full;
   assign cmd.del   = accept && (req_op == OP_REMOVE) && found;
   assign cmd.value = req_value;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign lefts[g] = '{value: '0, valid: 1'b1, take: 1'b0, seen: 1'b0};
         end else begin : g_mid
            assign lefts[g] = cells[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign rights[g] = '{value: '0, valid: 1'b0, take: 1'b1, seen: 1'b0};
         end else begin : g_inner
            assign rights[g] = cells[g+1];
         end
         slli_cell u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .left  (lefts[g]),
            .right (rights[g]),
            .self  (cells[g])
         );
      end
   endgenerate

   always_comb begin
      count_in    = count_ff;
      status_in   = ST_NOT_FOUND;
      smallest_in = cells[0].valid ? cells[0].value : '0;
      if (req_op == OP_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in   = ST_INSERTED;
            count_in    = count_ff + CW'(1);
            smallest_in = cells[0].take ? req_value : cells[0].value;
         end
      end else if (found) begin
         status_in = ST_REMOVED;
         count_in  = count_ff - CW'(1);
         if (cells[0].seen) begin
            smallest_in = cells[1].valid ? cells[1].value : '0;
         end
      end
   end

   assign count_ext = {{COUNT_WIDTH{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff   <= status_in;
         rsp_count_ff    <= count_ext[COUNT_WIDTH-1:0];
         rsp_smallest_ff <= smallest_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_smallest = $signed(rsp_smallest_ff);

   logic [CAPACITY-1:0] valid_vec;
   logic [CAPACITY-1:0] order_ok;

   generate
      for (g = 0; g < CAPACITY; g++) begin : g_chk
         assign valid_vec[g] = cells[g].valid;
         if (g == CAPACITY - 1) begin : g_end
            assign order_ok[g] = 1'b1;
         end else begin : g_pair
            assign order_ok[g] = !(cells[g].valid && cells[g+1].valid) ||
                                 !($signed(cells[g+1].value) < $signed(cells[g].value));
         end
      end
   endgenerate

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("count does not match occupied cells");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("stored values out of order");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_INSERT && full |=> $stable(count_ff))
      else $error("dropped insert changed the list");

endmodule
